FILE: rtl/core/fts_pkg.sv
`default_nettype none
package fts_pkg;

    localparam int STEP_W   = 24;
    localparam int LIMIT_W  = 16;
    localparam int ADDED_W  = 17;
    localparam int SECS_W   = 23;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [STEP_W-1:0]  STEP_RESET    = 24'd1089590;
    localparam logic [LIMIT_W-1:0] CATCHUP_RESET = 16'd256;
    localparam logic [LIMIT_W-1:0] SETBACK_RESET = 16'd256;

    localparam logic [1:0] REG_STEP    = 2'd0;
    localparam logic [1:0] REG_CATCHUP = 2'd1;
    localparam logic [1:0] REG_SETBACK = 2'd2;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam int MS_PER_SECOND = 1000;

    // ms / 1000 as (ms * DIV_MAGIC) >> DIV_SHIFT, exact for every 32-bit reading
    localparam int              MAGIC_W   = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
    localparam int              DIV_SHIFT = 38;
    localparam int              PROD_W    = 32 + MAGIC_W;

    typedef struct packed {
        logic [STEP_W-1:0]  step_increment;
        logic [LIMIT_W-1:0] catchup_limit;
        logic [LIMIT_W-1:0] setback_limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic div_step;
        logic eval;
        logic loop_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_loop;
        logic loop_go;
    } t_status;

endpackage
`default_nettype wire

FILE: rtl/core/fts_if.sv
`default_nettype none
interface fts_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] time_ms;

    modport source (output valid, output op, output time_ms, input ready);
    modport sink   (input valid, input op, input time_ms, output ready);
endinterface

interface fts_out_if;
    logic        valid;
    logic        ready;
    logic        ticked;
    logic [16:0] ticks_added;
    logic [31:0] tick_total;
    logic        interrupted;
    logic        clock_set_back;
    logic [22:0] seconds_now;
    logic        seconds_changed;

    modport source (
        output valid, output ticked, output ticks_added, output tick_total,
        output interrupted, output clock_set_back, output seconds_now,
        output seconds_changed, input ready
    );
    modport sink (
        input valid, input ticked, input ticks_added, input tick_total,
        input interrupted, input clock_set_back, input seconds_now,
        input seconds_changed, output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/fts_regs.sv
`default_nettype none
module fts_regs import fts_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_increment <= STEP_RESET;
            r_cfg.catchup_limit  <= CATCHUP_RESET;
            r_cfg.setback_limit  <= SETBACK_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_STEP:    r_cfg.step_increment <= pwdata[STEP_W-1:0];
                REG_CATCHUP: r_cfg.catchup_limit  <= pwdata[LIMIT_W-1:0];
                REG_SETBACK: r_cfg.setback_limit  <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_STEP:    prdata = APB_DW'(r_cfg.step_increment);
            REG_CATCHUP: prdata = APB_DW'(r_cfg.catchup_limit);
            REG_SETBACK: prdata = APB_DW'(r_cfg.setback_limit);
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/fts_ctrl.sv
`default_nettype none
module fts_ctrl import fts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  t_status   i_status,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_LOOP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]           r_state, n_state;
    logic                 r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_loop ? S_LOOP : S_DONE;
            end
            S_LOOP: begin
                if (i_status.loop_go) begin
                    o_cmd.loop_step = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending one");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIV))
        else $error("request did not start division");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_loop_only_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.loop_step |-> (r_state == S_LOOP && i_status.loop_go))
        else $error("catch-up step without go");

endmodule
`default_nettype wire

FILE: rtl/core/fts_dp.sv
`default_nettype none
module fts_dp import fts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  wire logic              i_op,
    input  wire logic [31:0]       i_time_ms,
    output logic                   o_ticked,
    output logic [ADDED_W-1:0]     o_ticks_added,
    output logic [31:0]            o_tick_total,
    output logic                   o_interrupted,
    output logic                   o_clock_set_back,
    output logic [SECS_W-1:0]      o_seconds_now,
    output logic                   o_seconds_changed
);

    localparam int ACC_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;

    logic [31:0]          r_last;
    logic [31:0]          r_due_ms;
    logic [FRAC_BITS-1:0] r_due_frac;
    logic [31:0]          r_ticks;
    logic [SECS_W-1:0]    r_cur_sec;

    logic                 r_op;
    logic [31:0]          r_reading;
    logic [SECS_W-1:0]    r_quo;
    logic [ADDED_W-1:0]   r_added;
    logic                 r_intr;
    logic                 r_setback;

    logic [ACC_W-1:0]     w_acc;
    logic [31:0]          w_adv_ms;
    logic [FRAC_BITS-1:0] w_adv_frac;
    logic [31:0]          w_rst_ms;
    logic [FRAC_BITS-1:0] w_rst_frac;
    logic [31:0]          w_diff;
    logic                 w_late;
    logic                 w_over;
    logic [32:0]          w_sb_sum;
    logic                 w_under;
    logic                 w_new;
    logic [PROD_W-1:0]    w_prod;
    logic [SECS_W-1:0]    w_secs;

    assign w_acc      = ACC_W'(r_due_frac) + ACC_W'(i_cfg.step_increment);
    assign w_adv_ms   = r_due_ms + 32'(w_acc >> FRAC_BITS);
    assign w_adv_frac = w_acc[FRAC_BITS-1:0];
    assign w_rst_ms   = r_reading + 32'(i_cfg.step_increment >> FRAC_BITS);
    assign w_rst_frac = i_cfg.step_increment[FRAC_BITS-1:0];

    assign w_diff   = r_reading - r_due_ms;
    assign w_late   = !w_diff[31];
    assign w_over   = w_diff > 32'(i_cfg.catchup_limit);
    assign w_sb_sum = {w_diff[31], w_diff} + 33'(i_cfg.setback_limit);
    assign w_under  = w_sb_sum[32];
    assign w_new    = (r_reading != r_last);

    assign w_prod = PROD_W'(r_reading) * PROD_W'(DIV_MAGIC);
    assign w_secs = r_quo;

    assign o_status.need_loop = (r_op == OP_SAMPLE) && w_new && w_late && !w_over;
    assign o_status.loop_go   = w_late && !r_added[ADDED_W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_reading <= i_time_ms;
            r_added   <= '0;
            r_intr    <= 1'b0;
            r_setback <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_quo <= w_prod[DIV_SHIFT +: SECS_W];
        end
        if (i_cmd.eval && r_op == OP_SAMPLE && w_new) begin
            if (w_late && w_over) begin
                r_added <= ADDED_W'(1);
                r_intr  <= 1'b1;
            end else if (!w_late && w_under) begin
                r_setback <= 1'b1;
            end
        end
        if (i_cmd.loop_step) begin
            r_added <= r_added + 1'b1;
        end
        if (i_cmd.finish) begin
            o_ticked          <= (r_added != '0);
            o_ticks_added     <= r_added;
            o_tick_total      <= r_ticks;
            o_interrupted     <= r_intr;
            o_clock_set_back  <= r_setback;
            o_seconds_now     <= w_secs;
            o_seconds_changed <= (r_op == OP_SAMPLE) && (r_cur_sec != w_secs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_due_ms   <= '0;
            r_due_frac <= '0;
            r_ticks    <= '0;
            r_cur_sec  <= '0;
        end else begin
            if (i_cmd.eval) begin
                if (r_op == OP_START) begin
                    r_last     <= r_reading;
                    r_due_ms   <= w_rst_ms;
                    r_due_frac <= w_rst_frac;
                end else if (w_new) begin
                    r_last <= r_reading;
                    if (w_late && w_over) begin
                        r_ticks    <= r_ticks + 1'b1;
                        r_due_ms   <= w_rst_ms;
                        r_due_frac <= w_rst_frac;
                    end else if (!w_late && w_under) begin
                        r_due_ms   <= w_rst_ms;
                        r_due_frac <= w_rst_frac;
                    end
                end
            end
            if (i_cmd.loop_step) begin
                r_ticks    <= r_ticks + 1'b1;
                r_due_ms   <= w_adv_ms;
                r_due_frac <= w_adv_frac;
            end
            if (i_cmd.finish) begin
                r_cur_sec <= w_secs;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/fractional_tick_scheduler.sv
// Paces a tick counter against a free-running millisecond reading with a
// fractional phase accumulator (FRAC_BITS fraction bits in step_increment).
// One result per request. A request passes through accept, a reciprocal
// multiply for the seconds value and evaluate; when it catches up ticks, a
// catch-up state then adds one tick per cycle through the accumulator adder,
// before the hand-off to the output register. The next request is accepted
// while a result waits in the output register; a result is held until taken,
// and the hand-off of the following one waits until the output register frees.
`default_nettype none
module fractional_tick_scheduler import fts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    fts_in_if.sink                 i_in,
    fts_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    fts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    fts_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_op              (i_in.op),
        .i_time_ms         (i_in.time_ms),
        .o_ticked          (o_out.ticked),
        .o_ticks_added     (o_out.ticks_added),
        .o_tick_total      (o_out.tick_total),
        .o_interrupted     (o_out.interrupted),
        .o_clock_set_back  (o_out.clock_set_back),
        .o_seconds_now     (o_out.seconds_now),
        .o_seconds_changed (o_out.seconds_changed)
    );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fts_pkg::*;

    localparam int FRAC          = 16;
    localparam int LIMIT_CYCLES  = 4_000_000;
    localparam int DRAIN_PAUSE   = 40;
    localparam int PHASE_ITEMS   = 160;
    localparam int RX_HOLD       = 600;
    localparam int AIM_CAP       = 300;
    localparam logic [16:0] MAX_CATCHUP = 17'h10000;

    typedef struct packed {
        logic        ticked;
        logic [16:0] ticks_added;
        logic [31:0] tick_total;
        logic        interrupted;
        logic        clock_set_back;
        logic [22:0] seconds_now;
        logic        seconds_changed;
    } tick_result_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    fts_in_if  req_if ();
    fts_out_if res_if ();

    fractional_tick_scheduler #(.FRAC_BITS(FRAC)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scheduler model state
    logic [STEP_W-1:0]  cfg_step    = STEP_RESET;
    logic [LIMIT_W-1:0] cfg_catchup = CATCHUP_RESET;
    logic [LIMIT_W-1:0] cfg_setback = SETBACK_RESET;
    logic [31:0]        sched_last_ms  = '0;
    logic [31:0]        sched_due_ms   = '0;
    logic [FRAC-1:0]    sched_due_frac = '0;
    logic [31:0]        sched_ticks    = '0;
    logic [31:0]        sched_secs     = '0;

    tick_result_t pending_tick_results[$];
    tick_result_t oldest_tick_result;
    int           mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    bit           tx_quiet       = 0;
    bit           rx_quiet       = 0;
    int           rx_hold_req    = 0;
    int           rx_hold_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int due_lateness(input logic [31:0] ms);
        return ms - sched_due_ms;
    endfunction

    function automatic void advance_due();
        logic [31:0] acc;
        acc = {16'b0, sched_due_frac} + {8'b0, cfg_step};
        sched_due_ms   = sched_due_ms + {16'b0, acc[31:FRAC]};
        sched_due_frac = acc[FRAC-1:0];
    endfunction

    function automatic void restart_due();
        sched_due_ms   = sched_last_ms;
        sched_due_frac = '0;
        advance_due();
    endfunction

    function automatic tick_result_t predict_tick_update(input logic op,
                                                         input logic [31:0] ms);
        tick_result_t res;
        logic [16:0]  added;
        logic [31:0]  secs;
        int           late_ms;
        int           catchup_ms;
        int           setback_ms;
        res        = '0;
        added      = '0;
        catchup_ms = {16'b0, cfg_catchup};
        setback_ms = {16'b0, cfg_setback};
        if (op == OP_START) begin
            sched_last_ms = ms;
            restart_due();
            secs       = sched_last_ms / MS_PER_SECOND;
            sched_secs = secs;
        end else begin
            if (ms != sched_last_ms) begin
                sched_last_ms = ms;
                late_ms = due_lateness(ms);
                if (late_ms >= 0) begin
                    if (late_ms > catchup_ms) begin
                        sched_ticks     = sched_ticks + 1;
                        added           = 17'd1;
                        res.interrupted = 1'b1;
                        restart_due();
                    end else begin
                        do begin
                            sched_ticks = sched_ticks + 1;
                            added       = added + 1;
                            advance_due();
                        end while (due_lateness(ms) >= 0 && added < MAX_CATCHUP);
                    end
                end else if (late_ms < -setback_ms) begin
                    res.clock_set_back = 1'b1;
                    restart_due();
                end
            end
            secs                = sched_last_ms / MS_PER_SECOND;
            res.seconds_changed = (sched_secs != secs);
            sched_secs          = secs;
        end
        res.ticked      = (added != 0);
        res.ticks_added = added;
        res.tick_total  = sched_ticks;
        res.seconds_now = secs[SECS_W-1:0];
        return res;
    endfunction

    task automatic send_request(input logic op, input logic [31:0] ms);
        int gap;
        req_if.valid   <= 1'b1;
        req_if.op      <= op;
        req_if.time_ms <= ms;
        do @(posedge i_clk); while (!req_if.ready);
        pending_tick_results.push_back(predict_tick_update(op, ms));
        gap = 0;
        if (!tx_quiet) begin
            while ($urandom_range(99) < 28) gap++;
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic finish_phase();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_tick_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_STEP:    cfg_step    = value[STEP_W-1:0];
            REG_CATCHUP: cfg_catchup = value[LIMIT_W-1:0];
            REG_SETBACK: cfg_setback = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_schedule(input logic [31:0] step, input logic [31:0] catchup,
                                input logic [31:0] setback);
        write_reg(REG_STEP, step);
        write_reg(REG_CATCHUP, catchup);
        write_reg(REG_SETBACK, setback);
    endtask

    task automatic send_random_request();
        int          pick;
        int          cap;
        logic [31:0] ms;
        pick = $urandom_range(99);
        cap  = (cfg_catchup > AIM_CAP) ? AIM_CAP : cfg_catchup;
        if (pick < 6) begin
            send_request(OP_START, $urandom);
        end else begin
            if (pick < 14)
                ms = sched_last_ms;
            else if (pick < 40)
                ms = sched_last_ms + $urandom_range(1, 40);
            else if (pick < 75)
                ms = sched_due_ms + $urandom_range(cap, 0);
            else if (pick < 82)
                ms = sched_due_ms + cfg_catchup + 1 + $urandom_range(50, 0);
            else if (pick < 90)
                ms = sched_due_ms - $urandom_range(cfg_setback, 0);
            else if (pick < 95)
                ms = sched_due_ms - cfg_setback - 1 - $urandom_range(100, 0);
            else
                ms = $urandom;
            send_request(OP_SAMPLE, ms);
        end
    endtask

    // reset config: boundaries, wrap, seconds
    task automatic test_directed_schedule();
        send_request(OP_START, 32'd0);
        send_request(OP_SAMPLE, 32'd0);
        send_request(OP_SAMPLE, 32'd10);
        send_request(OP_SAMPLE, sched_due_ms);
        send_request(OP_SAMPLE, sched_due_ms + cfg_catchup);
        send_request(OP_SAMPLE, sched_due_ms + cfg_catchup + 1);
        send_request(OP_SAMPLE, sched_due_ms - cfg_setback);
        send_request(OP_SAMPLE, sched_due_ms - cfg_setback - 1);
        send_request(OP_START, 32'hFFFF_FFF8);
        send_request(OP_SAMPLE, 32'hFFFF_FFFF);
        send_request(OP_SAMPLE, 32'd20);
        send_request(OP_START, 32'd999);
        send_request(OP_SAMPLE, 32'd1000);
        send_request(OP_START, 32'hFFFF_FFFF);
        send_request(OP_SAMPLE, sched_due_ms + 32'h7FFF_FFFF);
        send_request(OP_SAMPLE, sched_due_ms + 32'h8000_0000);
        send_request(OP_START, 32'h5555_5555);
        send_request(OP_SAMPLE, 32'hAAAA_AAAA);
        finish_phase();
    endtask

    // register extremes, including the catch-up bound
    task automatic test_catchup_extremes();
        set_schedule(32'd65536, 32'd65535, 32'd65535);
        send_request(OP_START, 32'd100);
        send_request(OP_SAMPLE, sched_due_ms + 32'd65535);
        send_request(OP_SAMPLE, sched_due_ms + 32'd65536);
        send_request(OP_SAMPLE, sched_due_ms - 32'd65535);
        send_request(OP_SAMPLE, sched_due_ms - 32'd65536);
        finish_phase();
        set_schedule(32'hFF_FFFF, 32'd0, 32'd0);
        send_request(OP_START, 32'd5000);
        send_request(OP_SAMPLE, sched_due_ms);
        send_request(OP_SAMPLE, sched_due_ms + 1);
        send_request(OP_SAMPLE, sched_due_ms - 1);
        send_request(OP_SAMPLE, sched_last_ms);
        finish_phase();
    endtask

    task automatic test_random_phases();
        int phase;
        int n;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_schedule(STEP_RESET, CATCHUP_RESET, SETBACK_RESET);
                1: set_schedule(32'd65536, 32'd65535, 32'd65535);
                2: set_schedule(32'hFF_FFFF, 32'd0, 32'd0);
                default: set_schedule($urandom_range(16777215, 65536),
                                      ($urandom_range(1)) ? $urandom_range(300, 0)
                                                          : $urandom_range(65535, 0),
                                      $urandom_range(65535, 0));
            endcase
            tx_quiet = (phase == 4);
            rx_quiet = (phase == 4);
            send_request(OP_START, $urandom);
            for (n = 0; n < PHASE_ITEMS; n++) send_random_request();
            finish_phase();
            tx_quiet = 0;
            rx_quiet = 0;
        end
    endtask

    // sink stalls long enough for the block to back up into its input
    task automatic test_input_backpressure();
        int n;
        tx_quiet    = 1;
        rx_hold_req = RX_HOLD;
        send_request(OP_START, $urandom);
        for (n = 0; n < 20; n++) send_request(OP_SAMPLE, sched_last_ms + $urandom_range(1, 30));
        tx_quiet = 0;
        finish_phase();
    endtask

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                res_if.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                res_if.ready <= rx_quiet || ($urandom_range(99) >= 28);
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_tick_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual total %0h",
                         $time, res_if.tick_total);
                mismatch_count++;
            end else begin
                oldest_tick_result = pending_tick_results.pop_front();
                compare_field("ticked", oldest_tick_result.ticked, res_if.ticked);
                compare_field("ticks_added", oldest_tick_result.ticks_added,
                              res_if.ticks_added);
                compare_field("tick_total", oldest_tick_result.tick_total,
                              res_if.tick_total);
                compare_field("interrupted", oldest_tick_result.interrupted,
                              res_if.interrupted);
                compare_field("clock_set_back", oldest_tick_result.clock_set_back,
                              res_if.clock_set_back);
                compare_field("seconds_now", oldest_tick_result.seconds_now,
                              res_if.seconds_now);
                compare_field("seconds_changed", oldest_tick_result.seconds_changed,
                              res_if.seconds_changed);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_if.valid   <= 1'b0;
        req_if.op      <= OP_START;
        req_if.time_ms <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_schedule();
        test_catchup_extremes();
        test_input_backpressure();
        test_random_phases();
        if (mismatch_count == 0 && pending_tick_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
